// File: hdl/audio_rate_convert_3_to_2_gain_unit_macros.svh
// assertion macros for the 3:2 rate converter with gain
// expects clk and arst_n in the scope of each use
`ifndef AUDIO_RATE_CONVERT_3_TO_2_GAIN_UNIT_MACROS_SVH
`define AUDIO_RATE_CONVERT_3_TO_2_GAIN_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define ARCG_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ARCG_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ARCG_ASSERT(name, prop, msg)
`define ARCG_NEVER(name, cond, msg)
`endif

`endif

// File: hdl/arcg_pkg.sv
// shared types and constants for the 3:2 rate converter with gain
// no dependencies
package arcg_pkg;

	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 9;
	localparam int INDEX_W  = 1;
	localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
	localparam int MAG_W    = 22;
	localparam int RECIP_W  = 23;
	localparam int RECIP_SHIFT = 29;
	localparam int QPROD_W  = MAG_W + RECIP_W;

	localparam int GAIN_DIV = 100;
	localparam int SAT_MAX_I = 32767;
	localparam int SAT_MIN_I = -32768;

	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = SAMPLE_W'(SAT_MAX_I);
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = SAMPLE_W'(SAT_MIN_I);

	// ceil(2^29 / 100), exact floor division for magnitudes below 2^22
	localparam logic [RECIP_W-1:0] RECIP_MUL =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + GAIN_DIV - 1) / GAIN_DIV);

	// product magnitudes at or above these saturate
	localparam logic [PROD_W-1:0] SAT_HI_MAG = PROD_W'((SAT_MAX_I + 1) * GAIN_DIV);
	localparam logic [PROD_W-1:0] SAT_LO_MAG = PROD_W'((-SAT_MIN_I + 1) * GAIN_DIV);

	localparam logic [INDEX_W-1:0] REG_RESAMPLE = INDEX_W'(0);
	localparam logic [INDEX_W-1:0] REG_GAIN     = INDEX_W'(1);

	localparam logic              RESAMPLE_RST = 1'b1;
	localparam logic [GAIN_W-1:0] GAIN_RST     = GAIN_W'(180);

	typedef struct packed {
		logic              resample_enable;
		logic [GAIN_W-1:0] gain_percent;
	} cfg_t;

endpackage

// File: hdl/arcg_group.sv
// group sequencer: 3:2 phase tracking, held sample and operand select
// depends on arcg_pkg
module arcg_group import arcg_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic                       end_of_stream,
	output logic                       op_valid,
	input  logic                       op_ready,
	output logic signed [SAMPLE_W-1:0] op_x
);

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_THIRD
	} phase_t;

	phase_t                      phase_q, phase_d;
	logic signed [SAMPLE_W-1:0]  held_q, held_d;
	logic                        v_s1;
	logic signed [SAMPLE_W-1:0]  x_s1;
	logic                        emit;
	logic signed [SAMPLE_W-1:0]  x_d;
	logic [SAMPLE_W:0]           sum;
	logic [SAMPLE_W:0]           sum_adj;
	logic                        accept;

	assign in_ready = !v_s1 || op_ready;
	assign accept   = in_valid && in_ready;

	// average truncating toward zero
	assign sum     = {held_q[SAMPLE_W-1], held_q} + {sample_in[SAMPLE_W-1], sample_in};
	assign sum_adj = sum + {{SAMPLE_W{1'b0}}, sum[SAMPLE_W]};

	always_comb begin
		emit    = 1'b0;
		x_d     = sample_in;
		phase_d = phase_q;
		held_d  = held_q;
		if (!cfg.resample_enable) begin
			phase_d = PH_FIRST;
			emit    = 1'b1;
		end else begin
			case (phase_q)
				PH_SECOND: begin
					if (end_of_stream) begin
						phase_d = PH_FIRST;
					end else begin
						emit    = 1'b1;
						x_d     = held_q;
						held_d  = sample_in;
						phase_d = PH_THIRD;
					end
				end
				PH_THIRD: begin
					emit    = 1'b1;
					x_d     = sum_adj[SAMPLE_W:1];
					phase_d = PH_FIRST;
				end
				default: begin
					held_d  = sample_in;
					if (end_of_stream) begin
						phase_d = PH_FIRST;
					end else begin
						phase_d = PH_SECOND;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			held_q  <= '0;
			v_s1    <= 1'b0;
			x_s1    <= '0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				held_q  <= held_d;
			end
			if (in_ready) begin
				v_s1 <= accept && emit;
			end
			if (accept && emit) begin
				x_s1 <= x_d;
			end
		end
	end

	assign op_valid = v_s1;
	assign op_x     = x_s1;

endmodule

// File: hdl/arcg_scale.sv
// gain pipeline: multiply by percent, divide by 100, saturate, output register
// depends on arcg_pkg and the assertion macro header
`include "audio_rate_convert_3_to_2_gain_unit_macros.svh"

module arcg_scale import arcg_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [GAIN_W-1:0]          gain_percent,
	input  logic                       op_valid,
	output logic                       op_ready,
	input  logic signed [SAMPLE_W-1:0] op_x,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] result
);

	logic                       v_s2, v_s3, v_q;
	logic                       rdy_s2, rdy_s3, rdy_q;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   p_s2;
	logic                       neg;
	logic [PROD_W-1:0]          mag;
	logic [QPROD_W-1:0]         qprod;
	logic [SAMPLE_W-1:0]        q_s3;
	logic                       neg_s3, sat_hi_s3, sat_lo_s3;
	logic signed [SAMPLE_W-1:0] res_d;
	logic signed [SAMPLE_W-1:0] out_q;

	assign rdy_q    = !v_q || out_ready;
	assign rdy_s3   = !v_s3 || rdy_q;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign op_ready = rdy_s2;

	assign prod  = op_x * $signed({1'b0, gain_percent});
	assign neg   = p_s2[PROD_W-1];
	assign mag   = neg ? PROD_W'(-p_s2) : PROD_W'(p_s2);
	assign qprod = QPROD_W'(mag[MAG_W-1:0]) * QPROD_W'(RECIP_MUL);

	always_comb begin
		if (sat_hi_s3) begin
			res_d = SAT_MAX;
		end else if (sat_lo_s3) begin
			res_d = SAT_MIN;
		end else if (neg_s3) begin
			res_d = SAMPLE_W'(-q_s3);
		end else begin
			res_d = q_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (rdy_s2) begin
				v_s2 <= op_valid;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_q) begin
				v_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && op_valid) begin
			p_s2 <= prod;
		end
		if (rdy_s3 && v_s2) begin
			q_s3      <= qprod[RECIP_SHIFT+SAMPLE_W-1:RECIP_SHIFT];
			neg_s3    <= neg;
			sat_hi_s3 <= !neg && (mag >= SAT_HI_MAG);
			sat_lo_s3 <= neg && (mag >= SAT_LO_MAG);
		end
		if (rdy_q && v_s3) begin
			out_q <= res_d;
		end
	end

	assign out_valid = v_q;
	assign result    = out_q;

	`ARCG_NEVER(a_sat_exclusive, v_s3 && sat_hi_s3 && sat_lo_s3, "both saturation flags set")
	`ARCG_ASSERT(a_quot_range, v_s3 && !sat_hi_s3 && !sat_lo_s3 |-> q_s3 <= SAMPLE_W'(-SAT_MIN_I), "quotient out of range without saturation")
	`ARCG_ASSERT(a_advance, v_s2 && rdy_s3 |=> v_s3, "beat lost between multiply and divide")
	`ARCG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_q), "pending beat changed")

endmodule

// File: hdl/audio_rate_convert_3_to_2_gain_unit.sv
// top level: 3:2 sample rate converter with percentage gain, stereo out
// depends on arcg_pkg, arcg_group, arcg_scale
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------
//  in      | in_valid/in_ready   | sample_in, end_of_stream
//  out     | out_valid/out_ready | left_sample, right_sample
//  cfg     | cfg_we              | cfg_index, cfg_data
//
// one input beat per cycle while in_ready is high; a result passes through these registers in order:
// operand register, gain multiply, reciprocal divide, saturate/output
// each stage advances when the next is empty or moving, so bubbles collapse
// reset is immediate, no clearing pass; resample on, gain 180 percent
module audio_rate_convert_3_to_2_gain_unit import arcg_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [INDEX_W-1:0]         cfg_index,
	input  logic [GAIN_W-1:0]          cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic                       end_of_stream,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] left_sample,
	output logic signed [SAMPLE_W-1:0] right_sample
);

	cfg_t                       cfg_q;
	logic                       op_valid;
	logic                       op_ready;
	logic signed [SAMPLE_W-1:0] op_x;
	logic signed [SAMPLE_W-1:0] result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resample_enable <= RESAMPLE_RST;
			cfg_q.gain_percent    <= GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RESAMPLE: cfg_q.resample_enable <= cfg_data[0];
				REG_GAIN:     cfg_q.gain_percent    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	arcg_group u_group (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample_in     (sample_in),
		.end_of_stream (end_of_stream),
		.op_valid      (op_valid),
		.op_ready      (op_ready),
		.op_x          (op_x)
	);

	arcg_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.gain_percent (cfg_q.gain_percent),
		.op_valid     (op_valid),
		.op_ready     (op_ready),
		.op_x         (op_x),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result       (result)
	);

	assign left_sample  = result;
	assign right_sample = result;

endmodule
